@@ design/fct_pkg.sv @@
// Package: shared types and constants for the frustum cull test unit.
`default_nettype none
package fct_pkg;

    localparam int NUM_PLANES  = 6;
    localparam int COORD_WIDTH = 32;
    localparam int CW          = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
    localparam int SLOT_W      = 3;
    localparam int PROD_W      = 2 * CW;
    localparam int ACC_W       = PROD_W + 4;

    typedef enum logic [1:0] {
        KIND_LOAD   = 2'd0,
        KIND_BOX    = 2'd1,
        KIND_SPHERE = 2'd2,
        KIND_TRI    = 2'd3
    } kind_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic [SLOT_W-1:0]  plane_slot;
        logic signed [31:0] coord_0;
        logic signed [31:0] coord_1;
        logic signed [31:0] coord_2;
        logic signed [31:0] coord_3;
        logic signed [31:0] coord_4;
        logic signed [31:0] coord_5;
        logic signed [31:0] coord_6;
        logic signed [31:0] coord_7;
        logic signed [31:0] coord_8;
    } in_word_t;

    typedef struct packed {
        logic             visible;
        logic [2:0]       rejecting_plane;
    } out_word_t;

    // Query word that travels down the cell chain.
    typedef struct packed {
        logic                 valid;
        logic                 sphere;
        logic signed [CW-1:0] lo_x;
        logic signed [CW-1:0] lo_y;
        logic signed [CW-1:0] lo_z;
        logic signed [CW-1:0] hi_x;
        logic signed [CW-1:0] hi_y;
        logic signed [CW-1:0] hi_z;
        logic signed [CW-1:0] radius;
        logic                 rejected;
        logic [2:0]           rej_plane;
    } query_t;

    // Plane load command broadcast to the cells.
    typedef struct packed {
        logic                 we;
        logic [SLOT_W-1:0]    slot;
        logic signed [CW-1:0] nx;
        logic signed [CW-1:0] ny;
        logic signed [CW-1:0] nz;
        logic signed [CW-1:0] w;
    } load_t;

endpackage
`default_nettype wire

@@ design/frustum_cull_test_unit.sv @@
// Top level: input decode, bounding, chain of plane cells and result register.
`default_nettype none
// Frustum cull test unit. A load word writes one of six planes (no result);
// box, sphere and triangle words each return one result. Every query enters
// an input stage at acceptance, then passes a chain of six plane cells, two
// register stages per cell, and a result register that drives m_valid. Tests
// flow one per cycle; the whole chain stalls when the result waits. A load is
// held off until no test is left in the input stage, the cells or the result
// register, so it never overtakes an earlier test.
module frustum_cull_test_unit (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire fct_pkg::in_word_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output fct_pkg::out_word_t      m_data
);
    import fct_pkg::*;

    query_t chain [NUM_PLANES+1];
    query_t head_reg;
    load_t  ld;
    logic   advance;
    logic   busy;
    out_word_t res_reg;
    logic   res_valid_reg;
    logic signed [CW-1:0] v [9];
    logic signed [CW-1:0] lo [3], hi [3];
    logic [NUM_PLANES:0] inflight;
    logic [NUM_PLANES-1:0] mid_busy;
    logic   is_load;

    always_comb begin
        v[0] = CW'(s_data.coord_0); v[1] = CW'(s_data.coord_1);
        v[2] = CW'(s_data.coord_2); v[3] = CW'(s_data.coord_3);
        v[4] = CW'(s_data.coord_4); v[5] = CW'(s_data.coord_5);
        v[6] = CW'(s_data.coord_6); v[7] = CW'(s_data.coord_7);
        v[8] = CW'(s_data.coord_8);
        for (int k = 0; k < 3; k++) begin
            lo[k] = (v[k] < v[k+3]) ? v[k] : v[k+3];
            hi[k] = (v[k] < v[k+3]) ? v[k+3] : v[k];
            if (s_data.kind == KIND_TRI) begin
                if (v[k+6] < lo[k]) lo[k] = v[k+6];
                if (v[k+6] > hi[k]) hi[k] = v[k+6];
            end
        end
    end

    // Stall the chain only when a finished result is still waiting.
    assign advance = !(res_valid_reg && !m_ready);
    assign is_load = (s_data.kind == KIND_LOAD);

    // A load waits until no test is in flight.
    always_comb begin
        busy = head_reg.valid || (inflight != '0) || (mid_busy != '0) || res_valid_reg;
    end

    assign s_ready = advance && !(is_load && busy);

    always_comb begin
        ld.we   = s_valid && s_ready && is_load;
        ld.slot = s_data.plane_slot;
        ld.nx   = v[0]; ld.ny = v[1]; ld.nz = v[2]; ld.w = v[3];
    end

    // Head stage: register the bounded query word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg.valid <= 1'b0;
        end else if (advance) begin
            head_reg.valid     <= s_valid && s_ready && !is_load;
            head_reg.sphere    <= (s_data.kind == KIND_SPHERE);
            head_reg.lo_x      <= lo[0]; head_reg.lo_y <= lo[1]; head_reg.lo_z <= lo[2];
            head_reg.hi_x      <= (s_data.kind == KIND_SPHERE) ? v[0] : hi[0];
            head_reg.hi_y      <= (s_data.kind == KIND_SPHERE) ? v[1] : hi[1];
            head_reg.hi_z      <= (s_data.kind == KIND_SPHERE) ? v[2] : hi[2];
            head_reg.radius    <= v[3];
            head_reg.rejected  <= 1'b0;
            head_reg.rej_plane <= 3'(NUM_PLANES);
        end
    end

    assign chain[0] = head_reg;

    // Track valid tests inside each cell for the load hazard.
    always_comb begin
        for (int i = 0; i <= NUM_PLANES; i++) inflight[i] = chain[i].valid;
    end

    genvar g;
    generate
        for (g = 0; g < NUM_PLANES; g++) begin : g_cell
            fct_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .cell_idx  (3'(g)),
                .ld        (ld),
                .advance   (advance),
                .q_in      (chain[g]),
                .q_out     (chain[g+1]),
                .mid_valid (mid_busy[g])
            );
        end
    endgenerate

    // Result register toward the output.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (advance) begin
            res_valid_reg           <= chain[NUM_PLANES].valid;
            res_reg.visible         <= !chain[NUM_PLANES].rejected;
            res_reg.rejecting_plane <= chain[NUM_PLANES].rej_plane;
        end
    end

    assign m_valid = res_valid_reg;
    assign m_data  = res_reg;
endmodule
`default_nettype wire

@@ design/fct_cell.sv @@
// One plane cell: holds a plane and tests the passing query word over two stages.
`default_nettype none
module fct_cell (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic [2:0]     cell_idx,
    input  wire fct_pkg::load_t ld,
    input  wire logic           advance,
    input  wire fct_pkg::query_t q_in,
    output fct_pkg::query_t     q_out,
    output logic                mid_valid
);
    import fct_pkg::*;

    logic signed [CW-1:0] nx_reg, ny_reg, nz_reg, w_reg;
    logic signed [PROD_W-1:0] px_reg, py_reg, pz_reg;
    query_t mid_reg, out_reg;
    logic signed [CW-1:0] cx, cy, cz;
    logic signed [ACC_W-1:0] sum;

    // Pick the corner furthest along the normal; spheres use the centre.
    always_comb begin
        cx = (q_in.sphere || nx_reg > 0) ? q_in.hi_x : q_in.lo_x;
        cy = (q_in.sphere || ny_reg > 0) ? q_in.hi_y : q_in.lo_y;
        cz = (q_in.sphere || nz_reg > 0) ? q_in.hi_z : q_in.lo_z;
    end

    // Hold the plane; reset clears it so every test passes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            nx_reg <= '0; ny_reg <= '0; nz_reg <= '0; w_reg <= '0;
        end else if (ld.we && ld.slot == cell_idx) begin
            nx_reg <= ld.nx; ny_reg <= ld.ny; nz_reg <= ld.nz; w_reg <= ld.w;
        end
    end

    // Stage one: three products.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_reg.valid <= 1'b0;
        end else if (advance) begin
            mid_reg <= q_in;
            px_reg  <= PROD_W'(nx_reg * cx);
            py_reg  <= PROD_W'(ny_reg * cy);
            pz_reg  <= PROD_W'(nz_reg * cz);
        end
    end

    // Stage two: sum with offset and radius, record the first rejection.
    always_comb begin
        sum = ACC_W'(px_reg) + ACC_W'(py_reg) + ACC_W'(pz_reg)
            + (ACC_W'(w_reg) <<< 16)
            + (mid_reg.sphere ? (ACC_W'(mid_reg.radius) <<< 16) : ACC_W'(0));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg.valid <= 1'b0;
        end else if (advance) begin
            out_reg <= mid_reg;
            if (!mid_reg.rejected && sum[ACC_W-1]) begin
                out_reg.rejected  <= 1'b1;
                out_reg.rej_plane <= cell_idx;
            end
        end
    end

    assign q_out     = out_reg;
    assign mid_valid = mid_reg.valid;
endmodule
`default_nettype wire
